// ===== design/bblp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bblp_pkg;

    localparam int SDNV_BITS   = 7;
    localparam int LEN_W       = 64;
    localparam int FLAGS_W     = 7;
    localparam int REFS_W      = 32;
    localparam int FLAG_IDX_W  = 3;
    localparam int RES_DATA_W  = 104;

    typedef enum logic [2:0] {
        PH_TYPE  = 3'd0,
        PH_FLAGS = 3'd1,
        PH_COUNT = 3'd2,
        PH_REFS  = 3'd3,
        PH_LEN   = 3'd4
    } phase_t;

    typedef enum logic [0:0] {
        REG_EID_FLAG_BIT = 1'b0
    } reg_index_t;

    typedef struct packed {
        logic                 valid;
        logic [LEN_W-1:0]     block_length;
        logic [FLAGS_W-1:0]   proc_flags;
        logic [REFS_W-1:0]    eid_ref_count;
    } result_t;

endpackage
`default_nettype wire

// ===== design/bblp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bblp_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready,
    output logic      [bblp_pkg::FLAG_IDX_W-1:0]    eid_flag_bit
);
    import bblp_pkg::*;

    logic [FLAG_IDX_W-1:0] eid_flag_bit_reg;
    logic                  wr_en;
    logic                  sel_flag;

    assign pready   = 1'b1;
    assign sel_flag = (reg_index_t'(paddr[2]) == REG_EID_FLAG_BIT);
    assign wr_en    = psel && penable && pwrite && sel_flag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eid_flag_bit_reg <= FLAG_IDX_W'(6);
        end else if (wr_en) begin
            eid_flag_bit_reg <= pwdata[FLAG_IDX_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_flag) begin
            prdata = {{(32-FLAG_IDX_W){1'b0}}, eid_flag_bit_reg};
        end
    end

    assign eid_flag_bit = eid_flag_bit_reg;

endmodule
`default_nettype wire

// ===== design/bblp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bblp_parser (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_accept,
    input  wire logic [7:0]                         in_byte,
    input  wire logic [bblp_pkg::FLAG_IDX_W-1:0]    eid_flag_bit,
    output bblp_pkg::result_t                       res
);
    import bblp_pkg::*;

    phase_t              phase_reg,          phase_next;
    logic [LEN_W-1:0]    sdnv_value_reg,     sdnv_value_next;
    logic [LEN_W-1:0]    header_bytes_reg,   header_bytes_next;
    logic [REFS_W-1:0]   refs_remaining_reg, refs_remaining_next;
    logic                ref_half_reg,       ref_half_next;
    logic [FLAGS_W-1:0]  flags_held_reg,     flags_held_next;
    logic [REFS_W-1:0]   refs_declared_reg,  refs_declared_next;

    logic                last_byte;
    logic [LEN_W-1:0]    sdnv_shifted;
    logic [LEN_W-1:0]    hdr_inc;
    logic [LEN_W:0]      total_sum;
    logic [FLAGS_W:0]    flags_ext;
    logic [FLAGS_W-1:0]  new_flags;

    assign last_byte    = !in_byte[7];
    assign sdnv_shifted = {sdnv_value_reg[LEN_W-SDNV_BITS-1:0], in_byte[SDNV_BITS-1:0]};
    assign hdr_inc      = (&header_bytes_reg) ? header_bytes_reg
                                              : header_bytes_reg + LEN_W'(1);
    assign total_sum    = {1'b0, hdr_inc} + {1'b0, sdnv_shifted};
    assign new_flags    = sdnv_shifted[FLAGS_W-1:0];
    assign flags_ext    = {1'b0, new_flags};

    always_comb begin
        phase_next          = phase_reg;
        sdnv_value_next     = sdnv_value_reg;
        header_bytes_next   = header_bytes_reg;
        refs_remaining_next = refs_remaining_reg;
        ref_half_next       = ref_half_reg;
        flags_held_next     = flags_held_reg;
        refs_declared_next  = refs_declared_reg;
        res                 = '0;
        res.block_length    = total_sum[LEN_W] ? '1 : total_sum[LEN_W-1:0];
        res.proc_flags      = flags_held_reg;
        res.eid_ref_count   = refs_declared_reg;
        if (in_accept) begin
            case (phase_reg)
                PH_FLAGS: begin
                    header_bytes_next = hdr_inc;
                    sdnv_value_next   = sdnv_shifted;
                    if (last_byte) begin
                        flags_held_next = new_flags;
                        sdnv_value_next = '0;
                        if (flags_ext[eid_flag_bit]) begin
                            phase_next = PH_COUNT;
                        end else begin
                            refs_declared_next  = '0;
                            refs_remaining_next = '0;
                            phase_next          = PH_LEN;
                        end
                    end
                end
                PH_COUNT: begin
                    header_bytes_next = hdr_inc;
                    sdnv_value_next   = sdnv_shifted;
                    if (last_byte) begin
                        refs_declared_next  = sdnv_shifted[REFS_W-1:0];
                        refs_remaining_next = sdnv_shifted[REFS_W-1:0];
                        ref_half_next       = 1'b0;
                        sdnv_value_next     = '0;
                        phase_next = (sdnv_shifted[REFS_W-1:0] == '0) ? PH_LEN : PH_REFS;
                    end
                end
                PH_REFS: begin
                    header_bytes_next = hdr_inc;
                    if (last_byte) begin
                        if (!ref_half_reg) begin
                            ref_half_next = 1'b1;
                        end else begin
                            ref_half_next       = 1'b0;
                            refs_remaining_next = refs_remaining_reg - REFS_W'(1);
                            if (refs_remaining_reg == REFS_W'(1)) begin
                                phase_next = PH_LEN;
                            end
                        end
                    end
                end
                PH_LEN: begin
                    header_bytes_next = hdr_inc;
                    sdnv_value_next   = sdnv_shifted;
                    if (last_byte) begin
                        res.valid           = 1'b1;
                        phase_next          = PH_TYPE;
                        sdnv_value_next     = '0;
                        header_bytes_next   = '0;
                        refs_remaining_next = '0;
                        ref_half_next       = 1'b0;
                    end
                end
                default: begin
                    header_bytes_next   = LEN_W'(1);
                    sdnv_value_next     = '0;
                    refs_remaining_next = '0;
                    ref_half_next       = 1'b0;
                    flags_held_next     = '0;
                    refs_declared_next  = '0;
                    phase_next          = PH_FLAGS;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_TYPE;
            sdnv_value_reg     <= '0;
            header_bytes_reg   <= '0;
            refs_remaining_reg <= '0;
            ref_half_reg       <= 1'b0;
            flags_held_reg     <= '0;
            refs_declared_reg  <= '0;
        end else begin
            phase_reg          <= phase_next;
            sdnv_value_reg     <= sdnv_value_next;
            header_bytes_reg   <= header_bytes_next;
            refs_remaining_reg <= refs_remaining_next;
            ref_half_reg       <= ref_half_next;
            flags_held_reg     <= flags_held_next;
            refs_declared_reg  <= refs_declared_next;
        end
    end

`ifndef SYNTH
    a_res_from_len: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (phase_reg == PH_LEN))
        else $error("result outside length phase");
    a_back_to_type: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> (phase_reg == PH_TYPE))
        else $error("no return to type phase after result");
    a_type_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TYPE) |-> (header_bytes_reg == '0 && sdnv_value_reg == '0))
        else $error("stale counters while waiting for type byte");
    a_refs_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_REFS) |-> (refs_remaining_reg != '0))
        else $error("reference phase with nothing remaining");
`endif

endmodule
`default_nettype wire

// ===== design/bblp_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bblp_out_buf (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire bblp_pkg::result_t                  push,
    output logic                                    push_ready,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [bblp_pkg::RES_DATA_W-1:0]    m_tdata
);
    import bblp_pkg::*;

    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop        = main_reg.valid && m_tready;
    assign push_ready = !skid_reg.valid;

    always_comb begin
        main_next = main_reg;
        skid_next = skid_reg;
        if (pop) begin
            if (skid_reg.valid) begin
                main_next       = skid_reg;
                skid_next.valid = 1'b0;
            end else if (push.valid) begin
                main_next = push;
            end else begin
                main_next.valid = 1'b0;
            end
        end else if (push.valid) begin
            if (!main_reg.valid) begin
                main_next = push;
            end else begin
                skid_next = push;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_reg.valid <= 1'b0;
            skid_reg.valid <= 1'b0;
        end else begin
            main_reg.valid <= main_next.valid;
            skid_reg.valid <= skid_next.valid;
        end
        main_reg.block_length  <= main_next.block_length;
        main_reg.proc_flags    <= main_next.proc_flags;
        main_reg.eid_ref_count <= main_next.eid_ref_count;
        skid_reg.block_length  <= skid_next.block_length;
        skid_reg.proc_flags    <= skid_next.proc_flags;
        skid_reg.eid_ref_count <= skid_next.eid_ref_count;
    end

    assign m_tvalid = main_reg.valid;
    assign m_tdata  = {1'b0, main_reg.eid_ref_count, main_reg.proc_flags,
                       main_reg.block_length};

`ifndef SYNTH
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_reg.valid |-> main_reg.valid)
        else $error("skid entry without output entry");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_reg.valid |-> !push.valid)
        else $error("push into full buffer");
    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_reg.valid && !m_tready) |=> (skid_reg.valid && main_reg.valid))
        else $error("entry lost while stalled");
`endif

endmodule
`default_nettype wire

// ===== design/bundle_block_length_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | dir | ports                      | payload
// ---------+-----+----------------------------+-------------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata  | data_byte[7:0]
// m_       | out | m_tvalid m_tready m_tdata  | block_length, proc_flags, eid_ref_count
// apb      | in  | psel penable pwrite paddr  | eid_flag_bit at address 0
//
// one header byte per cycle while s_tready is high; each byte updates the parse registers in the cycle it is taken
// the result is registered into the main or skid output entry when the last data length byte is taken
// a two-entry output buffer keeps s_tready high while one result waits on m_tready
// s_tready drops only when both output entries are full
// aresetn is synchronous; the parser returns to waiting for a type byte, eid_flag_bit to 6
module bundle_block_length_parser_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // data_byte[7:0]
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic      [103:0]  m_tdata,   // block_length[63:0], proc_flags[70:64],
                                          // eid_ref_count[102:71], zero[103]
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);
    import bblp_pkg::*;

    logic [FLAG_IDX_W-1:0] eid_flag_bit;
    logic                  in_accept;
    logic                  push_ready;
    result_t               res;

    assign s_tready  = push_ready;
    assign in_accept = s_tvalid && push_ready;

    bblp_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .eid_flag_bit (eid_flag_bit)
    );

    bblp_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .in_byte      (s_tdata),
        .eid_flag_bit (eid_flag_bit),
        .res          (res)
    );

    bblp_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire
